// ----- design/gtl_pkg.sv -----
// gtl_pkg: shared types and constants for the GraphQL token lexer.
// No dependencies.
package gtl_pkg;

  typedef enum logic [3:0] {
    M_IDLE = 4'd0, M_STR = 4'd1, M_ESC = 4'd2, M_CMT = 4'd3, M_DOT1 = 4'd4,
    M_DOT2 = 4'd5, M_INT = 4'd6, M_FRAC = 4'd7, M_EXP = 4'd8, M_EXPD = 4'd9,
    M_NAME = 4'd10
  } lex_mode_t;

  localparam logic [4:0] K_NAME   = 5'd0;
  localparam logic [4:0] K_STRING = 5'd1;
  localparam logic [4:0] K_INT    = 5'd2;
  localparam logic [4:0] K_FLOAT  = 5'd3;
  localparam logic [4:0] K_BOOL   = 5'd4;
  localparam logic [4:0] K_NULL   = 5'd5;
  localparam logic [4:0] K_SPREAD = 5'd15;
  localparam logic [4:0] K_ERROR  = 5'd19;
  localparam logic [4:0] K_EOF    = 5'd20;

  localparam logic [2:0] KW_NONE  = 3'd0;
  localparam logic [2:0] KW_TRUE  = 3'd1;
  localparam logic [2:0] KW_FALSE = 3'd2;
  localparam logic [2:0] KW_NULL  = 3'd3;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_source;
  } in_word_t;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [31:0] start_offset;
    logic [15:0] token_length;
    logic [15:0] line_number;
    logic [15:0] column_number;
    logic        last_of_run;
  } out_word_t;

  // keyword spelling check: byte at position idx of keyword kw
  function automatic logic kw_byte_ok(logic [2:0] kw, logic [15:0] idx, logic [7:0] b);
    logic ok;
    ok = 1'b0;
    unique case (kw)
      KW_TRUE: begin
        unique case (idx)
          16'd1: ok = (b == "r");
          16'd2: ok = (b == "u");
          16'd3: ok = (b == "e");
          default: ok = 1'b0;
        endcase
      end
      KW_FALSE: begin
        unique case (idx)
          16'd1: ok = (b == "a");
          16'd2: ok = (b == "l");
          16'd3: ok = (b == "s");
          16'd4: ok = (b == "e");
          default: ok = 1'b0;
        endcase
      end
      KW_NULL: begin
        unique case (idx)
          16'd1: ok = (b == "u");
          16'd2: ok = (b == "l");
          16'd3: ok = (b == "l");
          default: ok = 1'b0;
        endcase
      end
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  function automatic logic [4:0] punct_kind(logic [7:0] b);
    logic [4:0] k;
    unique case (b)
      "{": k = 5'd6;
      "}": k = 5'd7;
      "(": k = 5'd8;
      ")": k = 5'd9;
      "[": k = 5'd10;
      "]": k = 5'd11;
      ":": k = 5'd12;
      "!": k = 5'd13;
      "@": k = 5'd14;
      "=": k = 5'd16;
      "&": k = 5'd17;
      "|": k = 5'd18;
      default: k = 5'd0;
    endcase
    return k;
  endfunction

endpackage

// ----- design/gtl_front.sv -----
// gtl_front: lexer state machine; turns one byte per cycle when in_ready is
// high, into up to three tokens, written as one bundle. Depends on gtl_pkg.
module gtl_front #(
  parameter int OFFSET_BITS = 32,
  parameter int LENGTH_BITS = 16,
  parameter int LINE_BITS   = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  gtl_pkg::in_word_t    in_word,
  output logic                 in_ready,
  output logic                 b_valid,
  output gtl_pkg::out_word_t [2:0] b_tok,
  output logic [1:0]           b_count,
  input  logic                 b_ready
);

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;
  localparam logic [LINE_BITS-1:0]   LC_MAX  = '1;

  gtl_pkg::lex_mode_t     lex_mode, lex_mode_next;
  logic [OFFSET_BITS-1:0] byte_position, byte_position_next;
  logic [OFFSET_BITS-1:0] token_start, token_start_next;
  logic [LENGTH_BITS-1:0] token_count, token_count_next;
  logic [LINE_BITS-1:0]   line_counter, line_counter_next;
  logic [LINE_BITS-1:0]   column_counter, column_counter_next;
  logic [2:0]             keyword_match, keyword_match_next;
  logic                   float_seen, float_seen_next;

  gtl_pkg::out_word_t [2:0] tok;
  logic [1:0]               n;
  logic                     fire;

  assign in_ready = !b_valid || b_ready;
  assign fire     = in_valid && in_ready;

  function automatic logic [LINE_BITS-1:0] col_add(logic [LINE_BITS-1:0] c,
                                                   logic [LENGTH_BITS-1:0] a);
    logic [LINE_BITS+LENGTH_BITS:0] s;
    s = (LINE_BITS+LENGTH_BITS+1)'(c) + (LINE_BITS+LENGTH_BITS+1)'(a);
    if (s >= (LINE_BITS+LENGTH_BITS+1)'(LC_MAX)) return LC_MAX;
    return s[LINE_BITS-1:0];
  endfunction

  function automatic logic [31:0] off32(logic [OFFSET_BITS-1:0] v);
    logic [OFFSET_BITS+31:0] w;
    w = (OFFSET_BITS+32)'(v);
    return w[31:0];
  endfunction

  function automatic logic [15:0] w16(logic [LENGTH_BITS-1:0] v);
    logic [LENGTH_BITS+15:0] w;
    w = (LENGTH_BITS+16)'(v);
    return w[15:0];
  endfunction

  function automatic logic [15:0] l16(logic [LINE_BITS-1:0] v);
    logic [LINE_BITS+15:0] w;
    w = (LINE_BITS+16)'(v);
    return w[15:0];
  endfunction

  always_comb begin
    logic [7:0] b;
    logic [4:0] pk;
    logic [4:0] nk;
    logic       dig, alpha, do_idle, do_flush;
    logic [OFFSET_BITS-1:0] p;
    gtl_pkg::out_word_t t;

    b   = in_word.byte_value;
    p   = byte_position;
    pk  = gtl_pkg::punct_kind(b);
    dig = (b >= "0") && (b <= "9");
    alpha = (b == "_") || ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
    lex_mode_next       = lex_mode;
    byte_position_next  = byte_position;
    token_start_next    = token_start;
    token_count_next    = token_count;
    line_counter_next   = line_counter;
    column_counter_next = column_counter;
    keyword_match_next  = keyword_match;
    float_seen_next     = float_seen;
    tok = '0;
    n   = 2'd0;
    do_idle  = 1'b0;
    do_flush = 1'b0;
    t = '0;
    nk = gtl_pkg::K_NAME;

    if (in_word.end_of_source) begin
      do_flush = 1'b1;
    end else begin
      byte_position_next = p + OFFSET_BITS'(1);
      unique case (lex_mode)
        gtl_pkg::M_STR: begin
          if (b == "\"") begin
            t = '0;
            t.token_kind   = gtl_pkg::K_STRING;
            t.start_offset = off32(token_start);
            t.token_length = w16(token_count);
            t.line_number  = l16(line_counter);
            t.column_number = l16(column_counter);
            tok[n] = t; n = n + 2'd1;
            lex_mode_next = gtl_pkg::M_IDLE;
          end else begin
            if (token_count != LEN_MAX) token_count_next = token_count + LENGTH_BITS'(1);
            if (b == "\\") lex_mode_next = gtl_pkg::M_ESC;
          end
        end
        gtl_pkg::M_ESC: begin
          if (token_count != LEN_MAX) token_count_next = token_count + LENGTH_BITS'(1);
          lex_mode_next = gtl_pkg::M_STR;
        end
        gtl_pkg::M_CMT: if (b == 8'h0A) do_idle = 1'b1;
        gtl_pkg::M_DOT1: begin
          if (b == ".") lex_mode_next = gtl_pkg::M_DOT2;
          else begin do_flush = 1'b1; do_idle = 1'b1; end
        end
        gtl_pkg::M_DOT2: begin
          if (b == ".") begin
            column_counter_next = col_add(column_counter, LENGTH_BITS'(3));
            t.token_kind   = gtl_pkg::K_SPREAD;
            t.start_offset = off32(token_start);
            t.token_length = 16'd3;
            t.line_number  = l16(line_counter);
            t.column_number = l16(column_counter_next);
            tok[n] = t; n = n + 2'd1;
            lex_mode_next = gtl_pkg::M_IDLE;
          end else begin do_flush = 1'b1; do_idle = 1'b1; end
        end
        gtl_pkg::M_INT, gtl_pkg::M_FRAC: begin
          if (dig) begin
            if (token_count != LEN_MAX) token_count_next = token_count + LENGTH_BITS'(1);
          end else if (b == "." && lex_mode == gtl_pkg::M_INT) begin
            float_seen_next = 1'b1;
            if (token_count != LEN_MAX) token_count_next = token_count + LENGTH_BITS'(1);
            lex_mode_next = gtl_pkg::M_FRAC;
          end else if (b == "e" || b == "E") begin
            float_seen_next = 1'b1;
            if (token_count != LEN_MAX) token_count_next = token_count + LENGTH_BITS'(1);
            lex_mode_next = gtl_pkg::M_EXP;
          end else begin do_flush = 1'b1; do_idle = 1'b1; end
        end
        gtl_pkg::M_EXP, gtl_pkg::M_EXPD: begin
          if (dig || (lex_mode == gtl_pkg::M_EXP && (b == "+" || b == "-"))) begin
            if (token_count != LEN_MAX) token_count_next = token_count + LENGTH_BITS'(1);
            lex_mode_next = gtl_pkg::M_EXPD;
          end else begin do_flush = 1'b1; do_idle = 1'b1; end
        end
        gtl_pkg::M_NAME: begin
          if (alpha || dig) begin
            if (keyword_match != gtl_pkg::KW_NONE &&
                !gtl_pkg::kw_byte_ok(keyword_match, w16(token_count), b))
              keyword_match_next = gtl_pkg::KW_NONE;
            if (token_count != LEN_MAX) token_count_next = token_count + LENGTH_BITS'(1);
          end else begin do_flush = 1'b1; do_idle = 1'b1; end
        end
        default: do_idle = 1'b1;
      endcase
    end

    // flush of the pending token; a pending pair of dots gives two error tokens
    if (do_flush) begin
      t = '0;
      t.line_number = l16(line_counter);
      unique case (lex_mode)
        gtl_pkg::M_STR, gtl_pkg::M_ESC: begin
          t.token_kind = gtl_pkg::K_STRING;
          t.start_offset = off32(token_start);
          t.token_length = w16(token_count);
          t.column_number = l16(column_counter_next);
          tok[n] = t; n = n + 2'd1;
        end
        gtl_pkg::M_DOT1, gtl_pkg::M_DOT2: begin
          column_counter_next = col_add(column_counter_next, LENGTH_BITS'(1));
          t.token_kind = gtl_pkg::K_ERROR;
          t.start_offset = off32(token_start);
          t.token_length = 16'd1;
          t.column_number = l16(column_counter_next);
          tok[n] = t; n = n + 2'd1;
          if (lex_mode == gtl_pkg::M_DOT2) begin
            column_counter_next = col_add(column_counter_next, LENGTH_BITS'(1));
            t.start_offset = off32(token_start + OFFSET_BITS'(1));
            t.column_number = l16(column_counter_next);
            tok[n] = t; n = n + 2'd1;
          end
        end
        gtl_pkg::M_INT, gtl_pkg::M_FRAC, gtl_pkg::M_EXP, gtl_pkg::M_EXPD,
        gtl_pkg::M_NAME: begin
          column_counter_next = col_add(column_counter_next, token_count);
          if (lex_mode == gtl_pkg::M_NAME) begin
            nk = gtl_pkg::K_NAME;
            if (keyword_match == gtl_pkg::KW_TRUE && token_count == LENGTH_BITS'(4))
              nk = gtl_pkg::K_BOOL;
            if (keyword_match == gtl_pkg::KW_FALSE && token_count == LENGTH_BITS'(5))
              nk = gtl_pkg::K_BOOL;
            if (keyword_match == gtl_pkg::KW_NULL && token_count == LENGTH_BITS'(4))
              nk = gtl_pkg::K_NULL;
          end else begin
            nk = float_seen ? gtl_pkg::K_FLOAT : gtl_pkg::K_INT;
          end
          t.token_kind = nk;
          t.start_offset = off32(token_start);
          t.token_length = w16(token_count);
          t.column_number = l16(column_counter_next);
          tok[n] = t; n = n + 2'd1;
        end
        default: ;
      endcase
      lex_mode_next = gtl_pkg::M_IDLE;
    end

    if (do_idle) begin
      lex_mode_next = gtl_pkg::M_IDLE;
      t = '0;
      t.start_offset = off32(p);
      t.token_length = 16'd1;
      t.line_number  = l16(line_counter_next);
      priority if (b == " " || b == 8'h09 || b == 8'h0D || b == ",") begin
        column_counter_next = col_add(column_counter_next, LENGTH_BITS'(1));
      end else if (b == 8'h0A) begin
        if (line_counter_next != LC_MAX) line_counter_next = line_counter_next + LINE_BITS'(1);
        column_counter_next = LINE_BITS'(1);
      end else if (b == "#") begin
        lex_mode_next = gtl_pkg::M_CMT;
      end else if (b == "\"") begin
        lex_mode_next = gtl_pkg::M_STR;
        token_start_next = p + OFFSET_BITS'(1);
        token_count_next = '0;
      end else if (pk != 5'd0) begin
        column_counter_next = col_add(column_counter_next, LENGTH_BITS'(1));
        t.token_kind = pk;
        t.column_number = l16(column_counter_next);
        tok[n] = t; n = n + 2'd1;
      end else if (b == ".") begin
        lex_mode_next = gtl_pkg::M_DOT1;
        token_start_next = p;
      end else if (b == "-" || dig) begin
        lex_mode_next = gtl_pkg::M_INT;
        token_start_next = p;
        token_count_next = LENGTH_BITS'(1);
        float_seen_next = 1'b0;
      end else if (alpha) begin
        lex_mode_next = gtl_pkg::M_NAME;
        token_start_next = p;
        token_count_next = LENGTH_BITS'(1);
        keyword_match_next = (b == "t") ? gtl_pkg::KW_TRUE :
                             (b == "f") ? gtl_pkg::KW_FALSE :
                             (b == "n") ? gtl_pkg::KW_NULL : gtl_pkg::KW_NONE;
      end else begin
        column_counter_next = col_add(column_counter_next, LENGTH_BITS'(1));
        t.token_kind = gtl_pkg::K_ERROR;
        t.column_number = l16(column_counter_next);
        tok[n] = t; n = n + 2'd1;
      end
    end

    if (in_word.end_of_source) begin
      t = '0;
      t.token_kind = gtl_pkg::K_EOF;
      t.start_offset = off32(byte_position);
      t.line_number = l16(line_counter);
      t.column_number = l16(column_counter_next);
      tok[n] = t; n = n + 2'd1;
      lex_mode_next       = gtl_pkg::M_IDLE;
      byte_position_next  = '0;
      token_start_next    = '0;
      token_count_next    = '0;
      line_counter_next   = LINE_BITS'(1);
      column_counter_next = LINE_BITS'(1);
      keyword_match_next  = gtl_pkg::KW_NONE;
      float_seen_next     = 1'b0;
    end
    if (n != 2'd0) tok[n-2'd1].last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lex_mode       <= gtl_pkg::M_IDLE;
      byte_position  <= '0;
      token_start    <= '0;
      token_count    <= '0;
      line_counter   <= LINE_BITS'(1);
      column_counter <= LINE_BITS'(1);
      keyword_match  <= gtl_pkg::KW_NONE;
      float_seen     <= 1'b0;
      b_valid        <= 1'b0;
    end else begin
      if (fire) begin
        lex_mode       <= lex_mode_next;
        byte_position  <= byte_position_next;
        token_start    <= token_start_next;
        token_count    <= token_count_next;
        line_counter   <= line_counter_next;
        column_counter <= column_counter_next;
        keyword_match  <= keyword_match_next;
        float_seen     <= float_seen_next;
      end
      if (in_ready) b_valid <= fire && (n != 2'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      b_tok   <= tok;
      b_count <= n;
    end
  end

  assert property (@(posedge clk) disable iff (rst) b_valid |-> b_count != 2'd0)
    else $error("empty bundle");
  assert property (@(posedge clk) disable iff (rst)
    b_valid && !b_ready |=> b_valid && $stable(b_count))
    else $error("bundle lost");
  assert property (@(posedge clk) disable iff (rst)
    fire && in_word.end_of_source |=> lex_mode == gtl_pkg::M_IDLE && byte_position == '0)
    else $error("end did not reset");

endmodule

// ----- design/gtl_back.sv -----
// gtl_back: unpacks token bundles into a one-token-per-pop output queue.
// Depends on gtl_pkg.
module gtl_back (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     b_valid,
  input  gtl_pkg::out_word_t [2:0] b_tok,
  input  logic [1:0]               b_count,
  output logic                     b_ready,
  output logic                     empty,
  output gtl_pkg::out_word_t       result,
  input  logic                     pop
);

  logic [1:0] idx;
  logic       last;

  assign empty   = !b_valid;
  assign result  = b_tok[idx];
  assign last    = (idx + 2'd1) == b_count;
  assign b_ready = pop && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (pop && b_valid) begin
      idx <= last ? 2'd0 : idx + 2'd1;
    end
  end

  assert property (@(posedge clk) disable iff (rst) b_valid |-> idx < b_count)
    else $error("index past bundle");
  assert property (@(posedge clk) disable iff (rst)
    b_valid && !empty && pop && !last |=> idx == $past(idx) + 2'd1)
    else $error("index not advanced");
  assert property (@(posedge clk) disable iff (rst) !b_valid |-> idx == 2'd0)
    else $error("stale index");

endmodule

// ----- design/graphql_token_lexer_unit.sv -----
// GraphQL token lexer. Source bytes enter through push/full, one per cycle
// while full is low; tokens leave through empty/pop, one per pop. A byte can
// produce zero to three tokens (flush of a pending token, the byte's own
// token, EOF); the front stage evaluates each byte combinationally and hands
// a bundle of up to three tokens to the back, which pops them one at a time.
// Sustained rate is one byte per cycle as long as each byte yields at most one
// token and pop keeps up; a byte yielding k tokens occupies the output for k
// pops. The front holds one bundle register; it accepts a new byte in the
// same cycle the last token of the waiting bundle is popped. last_of_run
// marks the final token of each byte. Depends on gtl_pkg, gtl_front, gtl_back.
module graphql_token_lexer_unit #(
  parameter int OFFSET_BITS = 32,
  parameter int LENGTH_BITS = 16,
  parameter int LINE_BITS   = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  gtl_pkg::in_word_t  in_data,
  output logic               empty,
  input  logic               pop,
  output gtl_pkg::out_word_t out_data
);

  logic                     b_valid, b_ready, in_ready;
  gtl_pkg::out_word_t [2:0] b_tok;
  logic [1:0]               b_count;

  assign full = !in_ready;

  gtl_front #(
    .OFFSET_BITS(OFFSET_BITS), .LENGTH_BITS(LENGTH_BITS), .LINE_BITS(LINE_BITS)
  ) u_front (
    .clk, .rst, .in_valid(push), .in_word(in_data), .in_ready,
    .b_valid, .b_tok, .b_count, .b_ready
  );

  gtl_back u_back (
    .clk, .rst, .b_valid, .b_tok, .b_count, .b_ready,
    .empty, .result(out_data), .pop
  );

  assert property (@(posedge clk) disable iff (rst)
    !empty && pop && out_data.last_of_run |-> !full)
    else $error("input not freed after last token");
  assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(out_data))
    else $error("token changed while waiting");
  assert property (@(posedge clk) disable iff (rst)
    !empty |-> out_data.token_kind <= gtl_pkg::K_EOF)
    else $error("bad token kind");

endmodule

// ----- test/graphql_token_lexer_unit_test.sv -----
// Self-checking testbench for graphql_token_lexer_unit: drives source bytes,
// predicts tokens with an internal lexer model and checks every popped word.
// Depends on gtl_pkg and the graphql_token_lexer_unit RTL.
module graphql_token_lexer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [15:0] SAT16 = 16'hFFFF;

  int error_count = 0;

  task automatic report(string what, int got, int want);
    $display("mismatch: %s got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  // Token predictor plus queue of expected output words.
  class token_scoreboard;
    gtl_pkg::out_word_t pending_tokens[$];
    gtl_pkg::lex_mode_t mode;
    logic [31:0] pos, tok_start;
    logic [15:0] tok_len, line_no, col_no;
    logic [2:0] kw;
    bit fseen;
    gtl_pkg::out_word_t run_words[$];

    function void clear();
      mode = gtl_pkg::M_IDLE; pos = '0; tok_start = '0; tok_len = '0;
      line_no = 16'd1; col_no = 16'd1; kw = gtl_pkg::KW_NONE; fseen = 0;
    endfunction

    function void col_add(logic [15:0] n);
      logic [16:0] s;
      s = {1'b0, col_no} + {1'b0, n};
      col_no = s[16] ? SAT16 : s[15:0];
    endfunction

    function void len_inc();
      if (tok_len != SAT16) tok_len++;
    endfunction

    function void emit(logic [4:0] k, logic [31:0] st, logic [15:0] len);
      gtl_pkg::out_word_t w;
      w.token_kind = k; w.start_offset = st; w.token_length = len;
      w.line_number = line_no; w.column_number = col_no; w.last_of_run = 0;
      run_words.push_back(w);
    endfunction

    function bit is_dig(logic [7:0] b);
      return b >= "0" && b <= "9";
    endfunction

    function bit is_alpha(logic [7:0] b);
      return b == "_" || (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function logic [4:0] punct_of(logic [7:0] b);
      case (b)
        "{": return 5'd6;  "}": return 5'd7;  "(": return 5'd8;
        ")": return 5'd9;  "[": return 5'd10; "]": return 5'd11;
        ":": return 5'd12; "!": return 5'd13; "@": return 5'd14;
        "=": return 5'd16; "&": return 5'd17; "|": return 5'd18;
        default: return 5'd0;
      endcase
    endfunction

    function bit kw_ok(logic [7:0] b);
      string s;
      s = (kw == gtl_pkg::KW_TRUE) ? "true" : (kw == gtl_pkg::KW_FALSE) ? "false" : "null";
      return tok_len < s.len() && s[tok_len] == b;
    endfunction

    function void flush_token();
      logic [4:0] k;
      case (mode)
        gtl_pkg::M_STR, gtl_pkg::M_ESC: emit(gtl_pkg::K_STRING, tok_start, tok_len);
        gtl_pkg::M_DOT1: begin
          col_add(16'd1); emit(gtl_pkg::K_ERROR, tok_start, 16'd1);
        end
        gtl_pkg::M_DOT2: begin
          col_add(16'd1); emit(gtl_pkg::K_ERROR, tok_start, 16'd1);
          col_add(16'd1); emit(gtl_pkg::K_ERROR, tok_start + 32'd1, 16'd1);
        end
        gtl_pkg::M_INT, gtl_pkg::M_FRAC, gtl_pkg::M_EXP, gtl_pkg::M_EXPD: begin
          col_add(tok_len);
          emit(fseen ? gtl_pkg::K_FLOAT : gtl_pkg::K_INT, tok_start, tok_len);
        end
        gtl_pkg::M_NAME: begin
          k = gtl_pkg::K_NAME;
          if ((kw == gtl_pkg::KW_TRUE && tok_len == 16'd4) ||
              (kw == gtl_pkg::KW_FALSE && tok_len == 16'd5)) k = gtl_pkg::K_BOOL;
          if (kw == gtl_pkg::KW_NULL && tok_len == 16'd4) k = gtl_pkg::K_NULL;
          col_add(tok_len); emit(k, tok_start, tok_len);
        end
        default: ;
      endcase
      mode = gtl_pkg::M_IDLE;
    endfunction

    function void idle_byte(logic [7:0] b);
      logic [4:0] k;
      k = punct_of(b);
      mode = gtl_pkg::M_IDLE;
      if (b == " " || b == 8'h09 || b == 8'h0d || b == ",") col_add(16'd1);
      else if (b == 8'h0a) begin
        if (line_no != SAT16) line_no++;
        col_no = 16'd1;
      end else if (b == "#") mode = gtl_pkg::M_CMT;
      else if (b == "\"") begin
        mode = gtl_pkg::M_STR; tok_start = pos + 32'd1; tok_len = '0;
      end else if (k != 5'd0) begin
        col_add(16'd1); emit(k, pos, 16'd1);
      end else if (b == ".") begin
        mode = gtl_pkg::M_DOT1; tok_start = pos;
      end else if (b == "-" || is_dig(b)) begin
        mode = gtl_pkg::M_INT; tok_start = pos; tok_len = 16'd1; fseen = 0;
      end else if (is_alpha(b)) begin
        mode = gtl_pkg::M_NAME; tok_start = pos; tok_len = 16'd1;
        kw = b == "t" ? gtl_pkg::KW_TRUE : b == "f" ? gtl_pkg::KW_FALSE :
             b == "n" ? gtl_pkg::KW_NULL : gtl_pkg::KW_NONE;
      end else begin
        col_add(16'd1); emit(gtl_pkg::K_ERROR, pos, 16'd1);
      end
    endfunction

    // Note one accepted input word and queue the tokens it produces.
    function void note_input(gtl_pkg::in_word_t w);
      logic [7:0] b;
      b = w.byte_value;
      run_words = {};
      if (w.end_of_source) begin
        flush_token(); emit(gtl_pkg::K_EOF, pos, 16'd0); clear();
      end else begin
        case (mode)
          gtl_pkg::M_STR:
            if (b == "\"") begin
              emit(gtl_pkg::K_STRING, tok_start, tok_len); mode = gtl_pkg::M_IDLE;
            end else begin
              len_inc();
              if (b == "\\") mode = gtl_pkg::M_ESC;
            end
          gtl_pkg::M_ESC: begin
            len_inc(); mode = gtl_pkg::M_STR;
          end
          gtl_pkg::M_CMT: if (b == 8'h0a) idle_byte(b);
          gtl_pkg::M_DOT1, gtl_pkg::M_DOT2:
            if (b == "." && mode == gtl_pkg::M_DOT1) mode = gtl_pkg::M_DOT2;
            else if (b == ".") begin
              col_add(16'd3); emit(gtl_pkg::K_SPREAD, tok_start, 16'd3);
              mode = gtl_pkg::M_IDLE;
            end else begin
              flush_token(); idle_byte(b);
            end
          gtl_pkg::M_INT, gtl_pkg::M_FRAC:
            if (is_dig(b)) len_inc();
            else if (b == "." && mode == gtl_pkg::M_INT) begin
              fseen = 1; len_inc(); mode = gtl_pkg::M_FRAC;
            end else if (b == "e" || b == "E") begin
              fseen = 1; len_inc(); mode = gtl_pkg::M_EXP;
            end else begin
              flush_token(); idle_byte(b);
            end
          gtl_pkg::M_EXP, gtl_pkg::M_EXPD:
            if (is_dig(b) || (mode == gtl_pkg::M_EXP && (b == "+" || b == "-"))) begin
              len_inc(); mode = gtl_pkg::M_EXPD;
            end else begin
              flush_token(); idle_byte(b);
            end
          gtl_pkg::M_NAME:
            if (is_alpha(b) || is_dig(b)) begin
              if (kw != gtl_pkg::KW_NONE && !kw_ok(b)) kw = gtl_pkg::KW_NONE;
              len_inc();
            end else begin
              flush_token(); idle_byte(b);
            end
          default: idle_byte(b);
        endcase
        pos++;
      end
      if (run_words.size() > 0) run_words[$].last_of_run = 1;
      foreach (run_words[i]) pending_tokens.push_back(run_words[i]);
    endfunction

    // Compare one popped word with the oldest expected token.
    task check_token(gtl_pkg::out_word_t got);
      gtl_pkg::out_word_t want;
      if (pending_tokens.size() == 0) begin
        report("unexpected token kind", int'(got.token_kind), -1);
        return;
      end
      want = pending_tokens.pop_front();
      if (got.token_kind != want.token_kind)
        report("token_kind", int'(got.token_kind), int'(want.token_kind));
      if (got.start_offset != want.start_offset)
        report("start_offset", int'(got.start_offset), int'(want.start_offset));
      if (got.token_length != want.token_length)
        report("token_length", int'(got.token_length), int'(want.token_length));
      if (got.line_number != want.line_number)
        report("line_number", int'(got.line_number), int'(want.line_number));
      if (got.column_number != want.column_number)
        report("column_number", int'(got.column_number), int'(want.column_number));
      if (got.last_of_run != want.last_of_run)
        report("last_of_run", int'(got.last_of_run), int'(want.last_of_run));
    endtask
  endclass

  logic clk = 0, rst = 1, push = 0, pop = 0;
  logic full, empty;
  gtl_pkg::in_word_t in_data = '0;
  gtl_pkg::out_word_t out_data;
  token_scoreboard sb;
  bit stim_done = 0;
  int idle_cycles = 0;

  graphql_token_lexer_unit u_top (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_data(in_data),
    .empty(empty), .pop(pop), .out_data(out_data)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // Mostly short gaps, occasionally a long stall; a third of the time none.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // push stays high from one word to the next when there is no gap
  task automatic send_word(logic [7:0] b, bit eos);
    int g;
    g = gap_len();
    if (g > 0) begin
      push <= 0;
      repeat (g) @(posedge clk);
    end
    push <= 1;
    in_data <= '{byte_value: b, end_of_source: eos};
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_input('{byte_value: b, end_of_source: eos});
  endtask

  task automatic send_text(string s);
    foreach (s[i]) send_word(s[i], 0);
  endtask

  // Result side: random pop, check at the edge where the word is taken.
  always @(posedge clk) begin
    if (!rst && pop && !empty) sb.check_token(out_data);
    pop <= ($urandom_range(0, 49) != 0) && (($urandom_range(0, 9) < 7) || stim_done);
  end

  // Watchdog: consecutive cycles with no accepted word on either side.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Well-formed fragments with random content make up most of the random part.
  function automatic string rand_fragment();
    string s, pool;
    int n;
    pool = "{}()[]:!@=&|";
    s = "";
    case ($urandom_range(0, 11))
      0: s = "true ";
      1: s = "false,";
      2: s = "null\n";
      3: begin
        s = "\"";
        n = $urandom_range(0, 6);
        repeat (n) s = {s, string'(8'($urandom_range(32, 126)))};
        s = {s, "\" "};
      end
      4: begin
        if ($urandom_range(0, 1)) s = "-";
        repeat ($urandom_range(1, 4)) s = {s, string'(8'($urandom_range(48, 57)))};
        if ($urandom_range(0, 1)) s = {s, ".", string'(8'($urandom_range(48, 57)))};
        if ($urandom_range(0, 1)) begin
          if ($urandom_range(0, 1)) s = {s, "e-7"};
          else s = {s, "e+7"};
        end
      end
      5: s = "...";
      6: s = string'(pool[$urandom_range(0, 11)]);
      7: s = "# note\n";
      8: begin
        s = string'(8'($urandom_range(97, 122)));
        repeat ($urandom_range(0, 5)) s = {s, string'(8'($urandom_range(97, 122)))};
        s = {s, " "};
      end
      9: s = {"..", string'(8'($urandom_range(97, 122)))};
      10: s = "\"a\\\"b\"";
      default: s = string'(8'($urandom_range(0, 255)));
    endcase
    return s;
  endfunction

  initial begin
    int sent;
    string frag;
    sb = new();
    sb.clear();
    repeat (7) @(posedge clk);
    rst <= 0;

    // Directed part: every punctuator, keywords, numbers, strings, dots.
    send_text("{}()[]:!@=&|");
    send_text(" true false null trux\t_A9,");
    send_text("-12.5e+3 -x 7E9 0. ");
    send_text("\"s\\\"q\" ... .. x . #c\n\r");
    send_word(8'hff, 0);
    send_word(8'h00, 0);
    send_word(8'h55, 1);
    send_text("\"open\\");
    send_word(8'haa, 1);
    send_text("#tail");
    send_word(8'h00, 1);
    send_text("..");
    send_word(8'h00, 1);

    // roughly 100 directed words above, about as many random ones here
    sent = 0;
    while (sent < 100) begin
      if ($urandom_range(0, 9) == 0) begin
        send_word(8'($urandom_range(0, 255)), 0);
        sent++;
      end else begin
        frag = rand_fragment();
        send_text(frag);
        sent += frag.len();
      end
      if ($urandom_range(0, 29) == 0) begin
        send_word(8'($urandom_range(0, 255)), 1);
        sent++;
      end
    end
    send_word(8'h00, 1);
    push <= 0;
    stim_done = 1;

    while (sb.pending_tokens.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
